// ----- sv/multi_channel_input_debouncer_top_assert.svh -----
// assertion macros for the multi-channel input debouncer
`ifndef MULTI_CHANNEL_INPUT_DEBOUNCER_TOP_ASSERT_SVH
`define MULTI_CHANNEL_INPUT_DEBOUNCER_TOP_ASSERT_SVH

`ifndef SYNTH
// property that holds in the same cycle
`define MCID_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// property whose consequent holds in the cycle after the antecedent
`define MCID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MCID_ASSERT(lbl, expr, msg)
`define MCID_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/mcid_pkg.sv -----
// shared types and constants of the multi-channel input debouncer
package mcid_pkg;

	localparam int CHANNELS    = 4;
	localparam int CHAN_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CHAN_NUM_W  = 3;
	localparam int MASK_W      = 4;
	localparam int LEVELS_W    = 4;
	localparam int TIME_W      = 32;
	localparam int DEB_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 8;

	localparam logic [MASK_W-1:0] ENABLE_RESET     = 4'd0;
	localparam logic [MASK_W-1:0] ACTIVE_LOW_RESET = 4'd15;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 16'd30;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE     = 2'd0,
		CFG_ACTIVE_LOW = 2'd1,
		CFG_DEBOUNCE   = 2'd2
	} cfg_idx_t;

	// item kinds carried in tuser
	typedef enum logic {
		CMD_POLL = 1'b0,
		CMD_SEED = 1'b1
	} cmd_t;

	// one pending change result of a channel
	typedef struct packed {
		logic level_high;
		logic is_active;
		logic active_changed;
	} res_t;

endpackage

// ----- sv/multi_channel_input_debouncer_top.sv -----
// multi-channel input debouncer: input register, single-pass update, result drain
// datapath: an accepted item is decoded from the input register, its changes enter the
// queue register and then the output register, where a receiver stall can hold them
// throughput: one item per cycle while items raise no change; an item raising changes holds
// the update stage until its last change is loaded, so receiver stalls hold the next item too
// reset: arst_n clears channel state, queue and valid flags and loads register defaults
module multi_channel_input_debouncer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// input items
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [mcid_pkg::S_TDATA_W-1:0]     s_tdata,  // levels[3:0], now_ms[35:4], zero pad
	input  logic                               s_tuser,  // cmd: 0 poll, 1 seed
	// result items
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mcid_pkg::M_TDATA_W-1:0]     m_tdata,  // channel[2:0], level_high[3],
	                                                     // is_active[4], active_changed[5], pad
	output logic                               m_tlast,  // last change raised by this poll
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mcid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcid_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mcid_pkg::*;

	// configuration registers
	logic [MASK_W-1:0] enable_q;
	logic [MASK_W-1:0] active_low_q;
	logic [DEB_W-1:0]  debounce_q;

	// input register stage
	logic                valid_s1;
	logic                cmd_s1;
	logic [LEVELS_W-1:0] levels_s1;
	logic [TIME_W-1:0]   now_s1;

	// per-channel debounce state
	logic [CHANNELS-1:0] stable_q;
	logic [CHANNELS-1:0] active_q;
	logic [CHANNELS-1:0] cand_q;
	logic [TIME_W-1:0]   since_q [CHANNELS];

	// change results waiting to drain, one slot per channel
	logic [CHANNELS-1:0] pend_q;
	res_t                res_q [CHANNELS];

	// output register
	logic                  out_valid_q;
	logic [M_TDATA_W-1:0]  out_data_q;
	logic                  out_last_q;

	// per-channel decode of the item in the input register
	logic [CHANNELS-1:0] lvl;
	logic [CHANNELS-1:0] act;
	logic [CHANNELS-1:0] fire;

	// drain selection
	logic [CHAN_IDX_W-1:0] sel_idx;
	logic [CHANNELS-1:0]   sel_bit;
	logic [CHANNELS-1:0]   pend_rest;
	logic [CHANNELS-1:0]   pend_clear;
	logic                  out_free;
	logic                  out_load;
	logic                  adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= ENABLE_RESET;
			active_low_q <= ACTIVE_LOW_RESET;
			debounce_q   <= DEBOUNCE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ENABLE:     enable_q     <= cfg_data[MASK_W-1:0];
				CFG_ACTIVE_LOW: active_low_q <= cfg_data[MASK_W-1:0];
				CFG_DEBOUNCE:   debounce_q   <= cfg_data[DEB_W-1:0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// input stage empties when its item is processed
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1    <= s_tuser;
			levels_s1 <= s_tdata[LEVELS_W-1:0];
			now_s1    <= s_tdata[LEVELS_W +: TIME_W];
		end
	end

	// an enabled channel fires on a poll when its level matched the candidate long enough
	// and differs from the stable level
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			lvl[i]  = levels_s1[i];
			act[i]  = active_low_q[i] ? ~levels_s1[i] : levels_s1[i];
			fire[i] = (cmd_s1 == CMD_POLL) && enable_q[i] && (lvl[i] == cand_q[i])
			          && (lvl[i] != stable_q[i])
			          && ((now_s1 - since_q[i]) >= {{(TIME_W-DEB_W){1'b0}}, debounce_q});
		end
	end

	// lowest pending channel goes out first
	always_comb begin
		sel_idx = '0;
		sel_bit = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel_idx = CHAN_IDX_W'(i);
			end
		end
		sel_bit[sel_idx] = pend_q[sel_idx];
	end

	assign pend_rest  = pend_q & ~sel_bit;
	assign out_free   = !out_valid_q || m_tready;
	assign out_load   = (pend_q != '0) && out_free;
	assign pend_clear = out_load ? pend_rest : pend_q;
	// the next item is processed once the queue empties, possibly in this very cycle
	assign adv_s1     = valid_s1 && (pend_clear == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			active_q <= '0;
			cand_q   <= '0;
			pend_q   <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				since_q[i] <= '0;
			end
		end else begin
			pend_q <= adv_s1 ? fire : pend_clear;
			if (adv_s1) begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (cmd_s1 == CMD_SEED) begin
						if (enable_q[i]) begin
							stable_q[i] <= lvl[i];
							active_q[i] <= act[i];
							cand_q[i]   <= lvl[i];
							since_q[i]  <= now_s1;
						end else begin
							// disabled on seed: levels cleared, timestamp kept
							stable_q[i] <= 1'b0;
							active_q[i] <= 1'b0;
							cand_q[i]   <= 1'b0;
						end
					end else if (enable_q[i]) begin
						if (lvl[i] != cand_q[i]) begin
							cand_q[i]  <= lvl[i];
							since_q[i] <= now_s1;
						end else if (fire[i]) begin
							stable_q[i] <= lvl[i];
							active_q[i] <= act[i];
						end
					end
				end
			end
		end
	end

	// result payload per channel, read by the drain before it is overwritten
	always_ff @(posedge clk) begin
		for (int i = 0; i < CHANNELS; i++) begin
			if (adv_s1 && fire[i]) begin
				res_q[i].level_high     <= lvl[i];
				res_q[i].is_active      <= act[i];
				res_q[i].active_changed <= act[i] ^ active_q[i];
			end
		end
	end

	// output register, refilled while the consumer takes the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (pend_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {{(M_TDATA_W - CHAN_NUM_W - 3){1'b0}},
			               res_q[sel_idx].active_changed,
			               res_q[sel_idx].is_active,
			               res_q[sel_idx].level_high,
			               CHAN_NUM_W'(sel_idx) + CHAN_NUM_W'(1)};
			out_last_q <= (pend_rest == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	`include "multi_channel_input_debouncer_top_assert.svh"

	// channel number of a shown result is always a real channel
	`MCID_ASSERT(a_chan_range, !out_valid_q || ((out_data_q[CHAN_NUM_W-1:0] != '0) && (out_data_q[CHAN_NUM_W-1:0] <= CHAN_NUM_W'(CHANNELS))), "result channel out of range")
	// a result loaded without last leaves further changes queued
	`MCID_ASSERT_NEXT(a_more_after_notlast, out_load && (pend_rest != '0), pend_q != '0, "queue empty after a non-last result")
	// a seed item never queues a result
	`MCID_ASSERT_NEXT(a_seed_silent, adv_s1 && (cmd_s1 == CMD_SEED), pend_q == '0, "seed item queued a result")
	// a stalled input side means an item is waiting behind queued results
	`MCID_ASSERT(a_stall_cause, s_tready || (valid_s1 && (pend_q != '0)), "input stalled with nothing queued")

endmodule

// ----- verif/multi_channel_input_debouncer_top_test.sv -----
// self-checking testbench for the multi-channel input debouncer top level
module multi_channel_input_debouncer_top_test;
	import mcid_pkg::*;

	// generous ceiling on the run length, in clock cycles
	localparam int CYCLE_LIMIT = 150000;
	// cycles the receiver holds off during the back-pressure phase
	localparam int HOLD_CYCLES = 80;
	// quiet cycles allowed after the last result before a register write
	localparam int SETTLE_CYCLES = 4;

	// one input item as the sender sees it
	typedef struct {
		cmd_t                cmd;
		logic [LEVELS_W-1:0] levels;
		logic [TIME_W-1:0]   now_ms;
	} sample_t;

	// one predicted change result
	typedef struct {
		logic [CHAN_NUM_W-1:0] channel;
		logic                  level_high;
		logic                  is_active;
		logic                  active_changed;
		logic                  last;
	} change_t;

	// clock, reset and block ports; the ones driven here are known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// items waiting to be offered, and changes waiting to come out
	sample_t sample_q[$];
	change_t change_q[$];

	// our own copy of the configuration, tracked from accepted register writes
	logic [MASK_W-1:0] en_mask = ENABLE_RESET;
	logic [MASK_W-1:0] al_mask = ACTIVE_LOW_RESET;
	logic [DEB_W-1:0]  hold_ms = DEBOUNCE_RESET;

	// per-channel debounce state of the predictor
	logic [CHANNELS-1:0] stable_lvl = '0;
	logic [CHANNELS-1:0] active_lvl = '0;
	logic [CHANNELS-1:0] cand_lvl   = '0;
	logic [TIME_W-1:0]   cand_since [CHANNELS] = '{default: '0};

	// traffic shaping, percentages out of a hundred
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;
	logic        hold_go   = 1'b0;
	int unsigned hold_left = 0;

	// stimulus cursor: current switch levels and wall time
	logic [LEVELS_W-1:0] cur_levels = '0;
	logic [TIME_W-1:0]   clock_ms   = '0;

	// bookkeeping
	logic        in_fire     = 1'b0;
	int unsigned cycle_cnt   = 0;
	int unsigned err_cnt     = 0;
	int unsigned items_in    = 0;
	int unsigned seeds_in    = 0;
	int unsigned results_out = 0;
	int unsigned reg_writes  = 0;

	multi_channel_input_debouncer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one line per mismatch, printing capped so a broken block cannot flood the log
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_cnt++;
		if (err_cnt <= 40)
			$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
	endtask

	// debounce behaviour of one accepted item; queues the change results it raises
	task automatic predict_changes(cmd_t cmd, logic [LEVELS_W-1:0] lv, logic [TIME_W-1:0] now);
		change_t found[$];
		change_t c;
		logic    l;
		logic    a;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			l = lv[ch];
			a = al_mask[ch] ? ~l : l;
			if (cmd == CMD_SEED) begin
				if (en_mask[ch]) begin
					stable_lvl[ch] = l;
					active_lvl[ch] = a;
					cand_lvl[ch]   = l;
					cand_since[ch] = now;
				end else begin
					// a disabled channel is cleared but keeps its timestamp
					stable_lvl[ch] = 1'b0;
					active_lvl[ch] = 1'b0;
					cand_lvl[ch]   = 1'b0;
				end
			end else if (en_mask[ch]) begin
				if (l != cand_lvl[ch]) begin
					// new level seen: restart the hold time
					cand_lvl[ch]   = l;
					cand_since[ch] = now;
				end else if (l != stable_lvl[ch] &&
				             TIME_W'(now - cand_since[ch]) >= TIME_W'(hold_ms)) begin
					c.channel        = CHAN_NUM_W'(ch + 1);
					c.level_high     = l;
					c.is_active      = a;
					c.active_changed = (a != active_lvl[ch]);
					c.last           = 1'b0;
					found.push_back(c);
					stable_lvl[ch] = l;
					active_lvl[ch] = a;
				end
			end
		end
		if (found.size() != 0)
			found[found.size()-1].last = 1'b1;
		foreach (found[k])
			change_q.push_back(found[k]);
	endtask

	// monitor: tracks register writes, predicts on accepted items, checks results
	always @(posedge clk) begin : watch
		change_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= s_tvalid && s_tready;
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_idx_t'(cfg_index))
					CFG_ENABLE:     en_mask = cfg_data[MASK_W-1:0];
					CFG_ACTIVE_LOW: al_mask = cfg_data[MASK_W-1:0];
					CFG_DEBOUNCE:   hold_ms = cfg_data[DEB_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_changes(cmd_t'(s_tuser), s_tdata[LEVELS_W-1:0],
				                s_tdata[LEVELS_W +: TIME_W]);
			if (m_tvalid && m_tready) begin
				results_out++;
				if (change_q.size() == 0) begin
					report_mismatch("result with nothing expected, tdata", m_tdata, 0);
				end else begin
					want = change_q.pop_front();
					if (m_tdata[2:0] != want.channel)
						report_mismatch("channel", m_tdata[2:0], want.channel);
					if (m_tdata[3] != want.level_high)
						report_mismatch("level_high", m_tdata[3], want.level_high);
					if (m_tdata[4] != want.is_active)
						report_mismatch("is_active", m_tdata[4], want.is_active);
					if (m_tdata[5] != want.active_changed)
						report_mismatch("active_changed", m_tdata[5], want.active_changed);
					if (m_tlast != want.last)
						report_mismatch("tlast", m_tlast, want.last);
				end
			end
		end
	end

	// driver: offers queued items and sets the receiver's readiness
	always @(negedge clk) begin : drive
		sample_t nxt;
		if (!s_tvalid || in_fire) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
				nxt = sample_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= nxt.cmd;
				s_tdata  <= {{(S_TDATA_W-LEVELS_W-TIME_W){1'b0}}, nxt.now_ms, nxt.levels};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
	end

	// long receiver hold-off, counted here so the stimulus can start it with one pulse
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("multi_channel_input_debouncer_top_test failed");
			$finish;
		end
	end

	task automatic queue_item(cmd_t c, logic [LEVELS_W-1:0] l, logic [TIME_W-1:0] t);
		sample_t s;
		s.cmd    = c;
		s.levels = l;
		s.now_ms = t;
		sample_q.push_back(s);
		items_in++;
		if (c == CMD_SEED)
			seeds_in++;
	endtask

	// sender pauses until every queued item is in and every change is out
	task automatic wait_drained();
		while (sample_q.size() != 0 || s_tvalid || change_q.size() != 0)
			@(posedge clk);
		// a last item that raises no change may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes only ever happen with the block idle
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-behaved switch activity, with seeds and some glitch noise mixed in
	task automatic queue_random(int n);
		int unsigned pick;
		int unsigned step;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			step = 32'(hold_ms) + 32'(hold_ms) / 2 + 3;
			if (pick < 6) begin
				queue_item(CMD_SEED, cur_levels, clock_ms);
			end else if (pick < 12) begin
				// noise: any levels at any time
				queue_item(CMD_POLL, LEVELS_W'($urandom_range(15)), $urandom());
			end else begin
				if ($urandom_range(99) < 30)
					cur_levels ^= LEVELS_W'($urandom_range(1, 15));
				clock_ms += $urandom_range(0, step);
				queue_item(CMD_POLL, cur_levels, clock_ms);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: everything disabled after reset, so a poll does nothing
		queue_item(CMD_POLL, 4'hF, 32'h0000_0000);
		write_reg(CFG_ENABLE, 16'h000F);
		// default polarity and hold time: seed, restart, just short, then exactly held
		queue_item(CMD_SEED, 4'h0, 32'd100);
		queue_item(CMD_POLL, 4'hF, 32'd110);
		queue_item(CMD_POLL, 4'hF, 32'd139);
		queue_item(CMD_POLL, 4'hF, 32'd140);
		queue_item(CMD_POLL, 4'h5, 32'd150);
		queue_item(CMD_POLL, 4'h5, 32'd180);
		// polarity flipped after seeding: active state compared with the stored one
		write_reg(CFG_ACTIVE_LOW, 16'h0000);
		queue_item(CMD_POLL, 4'hA, 32'd200);
		queue_item(CMD_POLL, 4'hA, 32'd230);
		// zero hold time, half the channels disabled
		write_reg(CFG_DEBOUNCE, 16'h0000);
		write_reg(CFG_ENABLE, 16'h0005);
		queue_item(CMD_POLL, 4'h5, 32'd231);
		queue_item(CMD_POLL, 4'h5, 32'd231);
		queue_item(CMD_SEED, 4'hF, 32'hFFFF_FFF0);
		// longest hold time across the 32-bit wrap
		write_reg(CFG_DEBOUNCE, 16'hFFFF);
		write_reg(CFG_ENABLE, 16'h000F);
		write_reg(CFG_ACTIVE_LOW, 16'h000A);
		queue_item(CMD_SEED, 4'h0, 32'hFFFF_FFF0);
		queue_item(CMD_POLL, 4'hF, 32'hFFFF_FFFF);
		queue_item(CMD_POLL, 4'hF, 32'h0000_FFFE);
		queue_item(CMD_POLL, 4'h0, 32'h0000_FFFF);
		queue_item(CMD_POLL, 4'h0, 32'h0001_FFFD);
		queue_item(CMD_POLL, 4'h0, 32'h8000_0000);
		queue_item(CMD_POLL, 4'h0, 32'h0000_0000);

		// back-pressure: receiver holds off while the sender keeps offering changes
		write_reg(CFG_DEBOUNCE, 16'h0000);
		write_reg(CFG_ACTIVE_LOW, 16'(LEVELS_W'($urandom_range(15))));
		clock_ms = 32'd5000;
		queue_item(CMD_SEED, 4'h0, clock_ms);
		wait_drained();
		@(negedge clk);
		hold_go = 1'b1;
		@(negedge clk);
		hold_go = 1'b0;
		for (int p = 0; p < 12; p++) begin
			cur_levels = p[0] ? 4'h0 : 4'hF;
			clock_ms += 2;
			queue_item(CMD_POLL, cur_levels, clock_ms);
			queue_item(CMD_POLL, cur_levels, clock_ms);
		end

		// random, no idling, starting just short of the time wrap
		write_reg(CFG_ENABLE, 16'h000F);
		write_reg(CFG_ACTIVE_LOW, 16'h000F);
		write_reg(CFG_DEBOUNCE, 16'd30);
		clock_ms = 32'hFFFF_FE00;
		queue_item(CMD_SEED, cur_levels, clock_ms);
		queue_random(55);

		// random, sender idle most of the time, zero hold time
		write_reg(CFG_ENABLE, 16'h000A);
		write_reg(CFG_ACTIVE_LOW, 16'h0006);
		write_reg(CFG_DEBOUNCE, 16'h0000);
		gap_pct = 70;
		queue_item(CMD_SEED, cur_levels, clock_ms);
		queue_random(55);

		// random, receiver stalling most of the time, longest hold time
		write_reg(CFG_ENABLE, 16'h000F);
		write_reg(CFG_ACTIVE_LOW, 16'h0000);
		write_reg(CFG_DEBOUNCE, 16'hFFFF);
		gap_pct   = 0;
		stall_pct = 70;
		queue_item(CMD_SEED, cur_levels, clock_ms);
		queue_random(25);
		wait_drained();
		queue_random(25);

		// random, both sides idling now and then, short odd hold time
		write_reg(CFG_ENABLE, 16'h0007);
		write_reg(CFG_ACTIVE_LOW, 16'h0009);
		write_reg(CFG_DEBOUNCE, 16'd7);
		gap_pct   = 30;
		stall_pct = 30;
		queue_item(CMD_SEED, cur_levels, clock_ms);
		queue_random(28);
		wait_drained();
		queue_random(28);

		wait_drained();
		repeat (8) @(posedge clk);
		if (change_q.size() != 0)
			report_mismatch("changes never delivered, count", change_q.size(), 0);
		$display("covered %0d items (%0d seeds) and %0d change results", items_in, seeds_in,
		         results_out);
		$display("over %0d register writes, five traffic patterns and one long hold-off",
		         reg_writes);
		if (err_cnt == 0)
			$display("multi_channel_input_debouncer_top_test passed");
		else
			$display("multi_channel_input_debouncer_top_test failed");
		$finish;
	end

endmodule

// ----- multi_channel_input_debouncer_top.f -----
+incdir+sv
sv/mcid_pkg.sv
sv/multi_channel_input_debouncer_top.sv
verif/multi_channel_input_debouncer_top_test.sv
